// ----- hw/rtl/abg_pkg.sv -----
// ----------------------------------------------------------------------------
// abg_pkg: shared types and constants of the anchor box generator
// Field widths, transaction structs, register indexes and state codes.
// ----------------------------------------------------------------------------
package abg_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MaxPriorsDef = 16;
  localparam int unsigned MaxGridDef   = 1024;

  // Field widths.
  localparam int unsigned SlotW    = 4;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned CellW    = 10;
  localparam int unsigned LayerW   = 11;
  localparam int unsigned ImgW     = 13;
  localparam int unsigned OffW     = 8;
  localparam int unsigned StepW    = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CoordW   = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Datapath widths.
  localparam int unsigned PosW   = CellW + OffW;      // cell centre, Q.8
  localparam int unsigned ProdAW = PosW + StepW;      // centre times image or step
  localparam int unsigned ProdBW = LayerW + SizeW;    // layer times prior size
  localparam int unsigned DenW   = LayerW + ImgW;     // layer times image
  localparam int unsigned NumW   = 44;                // signed numerator
  localparam int unsigned DivdW  = 42;                // 2|N| + D
  localparam int unsigned DivsW  = DenW + 1;          // 2D
  localparam int unsigned QuoW   = CoordW + 1;        // quotient plus overflow bit
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned DvsW   = DivsW + QuoW - 1;

  localparam int unsigned QueueDepth = 2;

  localparam logic [CoordW-1:0] CoordOne    = 20'h10000;
  localparam logic [CoordW-1:0] CoordMaxPos = 20'h7FFFF;
  localparam logic [CoordW-1:0] CoordMinNeg = 20'h80000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CELL = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP         = 3'd0,
    CFG_OFFSET       = 3'd1,
    CFG_STEP_X       = 3'd2,
    CFG_STEP_Y       = 3'd3,
    CFG_IMG_W        = 3'd4,
    CFG_IMG_H        = 3'd5,
    CFG_PRIOR_COUNT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic              operation;
    logic [SlotW-1:0]  prior_slot;
    logic [SizeW-1:0]  prior_width;
    logic [SizeW-1:0]  prior_height;
    logic [CellW-1:0]  cell_col;
    logic [CellW-1:0]  cell_row;
    logic [LayerW-1:0] map_width;
    logic [LayerW-1:0] map_height;
    logic [ImgW-1:0]   image_width_in;
    logic [ImgW-1:0]   image_height_in;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]         prior_index;
    logic signed [CoordW-1:0] x_min;
    logic signed [CoordW-1:0] y_min;
    logic signed [CoordW-1:0] x_max;
    logic signed [CoordW-1:0] y_max;
    logic                     last_box;
  } out_item_t;

  typedef struct packed {
    logic              clip_enable;
    logic [OffW-1:0]   center_offset;
    logic [StepW-1:0]  step_x;
    logic [StepW-1:0]  step_y;
    logic [ImgW-1:0]   image_width_set;
    logic [ImgW-1:0]   image_height_set;
    logic [CountW-1:0] prior_count;
  } cfg_t;

  // Classified work item held in the queue between front and back.
  typedef struct packed {
    op_e               op;
    logic [SlotW-1:0]  slot;
    logic [SizeW-1:0]  pw;
    logic [SizeW-1:0]  ph;
    logic [CellW-1:0]  col;
    logic [CellW-1:0]  row;
    logic [LayerW-1:0] lw;
    logic [LayerW-1:0] lh;
    logic [ImgW-1:0]   iw;
    logic [ImgW-1:0]   ih;
  } work_t;

  typedef struct packed {
    logic             start;
    logic [DivdW-1:0] dividend;
    logic [DivsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/abg_front.sv -----
// ----------------------------------------------------------------------------
// abg_front: input classification
// Accepts input transactions, resolves layer and image sizes and pushes a
// classified work item into the queue.
// ----------------------------------------------------------------------------
module abg_front #(
  parameter int unsigned MaxGrid = abg_pkg::MaxGridDef
) (
  input  logic              in_valid_i,
  input  abg_pkg::in_item_t in_data_i,
  input  abg_pkg::cfg_t     cfg_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output abg_pkg::work_t    entry_o
);

  // A zero layer counts as one; a layer beyond the grid limit saturates.
  function automatic logic [abg_pkg::LayerW-1:0] sat_layer(
    input logic [abg_pkg::LayerW-1:0] l
  );
    logic [abg_pkg::LayerW-1:0] r;
    if (l == '0) begin
      r = abg_pkg::LayerW'(1);
    end else if (13'(l) > 13'(MaxGrid)) begin
      r = abg_pkg::LayerW'(MaxGrid);
    end else begin
      r = l;
    end
    return r;
  endfunction

  function automatic logic [abg_pkg::ImgW-1:0] pick_img(
    input logic [abg_pkg::ImgW-1:0] set,
    input logic [abg_pkg::ImgW-1:0] fld
  );
    logic [abg_pkg::ImgW-1:0] r;
    r = (set != '0) ? set : fld;
    if (r == '0) begin
      r = abg_pkg::ImgW'(1);
    end
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    entry_o.op   = abg_pkg::op_e'(in_data_i.operation);
    entry_o.slot = in_data_i.prior_slot;
    entry_o.pw   = in_data_i.prior_width;
    entry_o.ph   = in_data_i.prior_height;
    entry_o.col  = in_data_i.cell_col;
    entry_o.row  = in_data_i.cell_row;
    entry_o.lw   = sat_layer(in_data_i.map_width);
    entry_o.lh   = sat_layer(in_data_i.map_height);
    entry_o.iw   = pick_img(cfg_i.image_width_set, in_data_i.image_width_in);
    entry_o.ih   = pick_img(cfg_i.image_height_set, in_data_i.image_height_in);
  end

endmodule

// ----- hw/rtl/abg_queue.sv -----
// ----------------------------------------------------------------------------
// abg_queue: short work queue
// A small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module abg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  abg_pkg::work_t entry_i,
  input  logic           pop_i,
  output abg_pkg::work_t entry_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (abg_pkg::QueueDepth > 1) ? $clog2(abg_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(abg_pkg::QueueDepth + 1);

  abg_pkg::work_t mem_q [abg_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(abg_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(abg_pkg::QueueDepth));
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- hw/rtl/abg_div.sv -----
// ----------------------------------------------------------------------------
// abg_div: radix-2 restoring divider
// Produces one quotient bit a cycle; the top bit flags a quotient that
// does not fit the coordinate range.
// ----------------------------------------------------------------------------
module abg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abg_pkg::div_req_t req_i,
  output abg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(abg_pkg::DivSteps);

  logic                           busy_q;
  logic [CntW-1:0]                cnt_q;
  logic [abg_pkg::DivdW-1:0]      rem_q;
  logic [abg_pkg::DvsW-1:0]       dvs_q;
  logic [abg_pkg::QuoW-1:0]       quo_q;
  logic                           ge;
  logic [abg_pkg::DvsW-1:0]       diff;

  assign ge   = abg_pkg::DvsW'(rem_q) >= dvs_q;
  assign diff = abg_pkg::DvsW'(rem_q) - dvs_q;

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(abg_pkg::DivSteps - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dvs_q <= {req_i.divisor, (abg_pkg::QuoW - 1)'(0)};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff[abg_pkg::DivdW-1:0];
      end
      quo_q <= {quo_q[abg_pkg::QuoW-2:0], ge};
      dvs_q <= dvs_q >> 1;
    end
  end

endmodule

// ----- hw/rtl/abg_back.sv -----
// ----------------------------------------------------------------------------
// abg_back: prior table and box sequencer
// Executes queued work: loads write the prior tables, cells step through
// the priors, form four numerators and hand them to the dividers.
// ----------------------------------------------------------------------------
module abg_back #(
  parameter int unsigned MaxPriors = abg_pkg::MaxPriorsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abg_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  abg_pkg::work_t     entry_i,
  output logic               pop_o,
  output abg_pkg::div_req_t  div_req_o [4],
  input  abg_pkg::div_rsp_t  div_rsp_i [4],
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output abg_pkg::out_item_t out_data_o
);

  localparam int unsigned TabW = (MaxPriors > 1) ? $clog2(MaxPriors) : 1;

  abg_pkg::back_state_e state_q, state_d;

  logic [abg_pkg::SizeW-1:0]  wtab_q [MaxPriors];
  logic [abg_pkg::SizeW-1:0]  htab_q [MaxPriors];

  abg_pkg::work_t             cell_q;
  logic [abg_pkg::CountW-1:0] cnt_q, s_q, eff_count;
  logic [abg_pkg::ProdAW-1:0] pa_q [2];
  logic [abg_pkg::ProdBW-1:0] pb_q [2];
  logic [abg_pkg::DenW-1:0]   den_q [2];
  logic signed [abg_pkg::NumW-1:0] num_q [4];

  logic                       out_valid_q;
  abg_pkg::out_item_t         out_q;

  logic pop, tab_we, cell_start, div_start, out_load, out_free, last, derived;
  logic [TabW-1:0]            tidx;
  logic [abg_pkg::SizeW-1:0]  bsz [2];
  logic [abg_pkg::PosW-1:0]   pos [2];
  logic [abg_pkg::StepW-1:0]  mult [2];
  logic [abg_pkg::LayerW-1:0] lay [2];
  logic [abg_pkg::ImgW-1:0]   img [2];
  logic [abg_pkg::StepW-1:0]  stp [2];

  // Clamp a rounded quotient into the coordinate range of the active mode.
  function automatic logic [abg_pkg::CoordW-1:0] clamp_coord(
    input logic                     neg,
    input logic [abg_pkg::QuoW-1:0] quo,
    input logic                     clip
  );
    logic                          ovf;
    logic [abg_pkg::CoordW-1:0]    q;
    logic [abg_pkg::CoordW-1:0]    r;
    ovf = quo[abg_pkg::QuoW-1];
    q   = quo[abg_pkg::CoordW-1:0];
    if (neg) begin
      if (clip) begin
        r = '0;
      end else if (ovf || (q > abg_pkg::CoordMinNeg)) begin
        r = abg_pkg::CoordMinNeg;
      end else begin
        r = '0 - q;
      end
    end else begin
      if (clip) begin
        r = (ovf || (q > abg_pkg::CoordOne)) ? abg_pkg::CoordOne : q;
      end else begin
        r = (ovf || q[abg_pkg::CoordW-1]) ? abg_pkg::CoordMaxPos : q;
      end
    end
    return r;
  endfunction

  assign derived   = (cfg_i.step_x == '0) && (cfg_i.step_y == '0);
  assign eff_count = (32'(cfg_i.prior_count) > MaxPriors) ?
                     abg_pkg::CountW'(MaxPriors) : cfg_i.prior_count;
  assign last      = (s_q + 1'b1) == cnt_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign tidx      = TabW'(s_q);
  assign pop_o     = pop;

  assign bsz[0] = wtab_q[tidx];
  assign bsz[1] = htab_q[tidx];
  assign pos[0] = {cell_q.col, cfg_i.center_offset};
  assign pos[1] = {cell_q.row, cfg_i.center_offset};
  assign lay[0] = cell_q.lw;
  assign lay[1] = cell_q.lh;
  assign img[0] = cell_q.iw;
  assign img[1] = cell_q.ih;
  assign stp[0] = cfg_i.step_x;
  assign stp[1] = cfg_i.step_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mult[a] = derived ? abg_pkg::StepW'(img[a]) : stp[a];
    end
  end

  always_comb begin
    state_d    = state_q;
    pop        = 1'b0;
    tab_we     = 1'b0;
    cell_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      abg_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          pop = 1'b1;
          if (entry_i.op == abg_pkg::OP_LOAD) begin
            tab_we = 32'(entry_i.slot) < MaxPriors;
          end else begin
            cell_start = 1'b1;
            if (eff_count != '0) begin
              state_d = abg_pkg::ST_MUL;
            end
          end
        end
      end
      abg_pkg::ST_MUL:   state_d = abg_pkg::ST_SUM;
      abg_pkg::ST_SUM:   state_d = abg_pkg::ST_START;
      abg_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = abg_pkg::ST_DIV;
      end
      abg_pkg::ST_DIV: begin
        if (!div_rsp_i[0].busy) begin
          state_d = abg_pkg::ST_EMIT;
        end
      end
      abg_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = last ? abg_pkg::ST_IDLE : abg_pkg::ST_MUL;
        end
      end
      default: state_d = abg_pkg::ST_IDLE;
    endcase
  end

  // Lanes: 0 left, 1 top, 2 right, 3 bottom; axis is the lane bit 0.
  always_comb begin
    logic [abg_pkg::NumW+1:0] den_e;
    logic [abg_pkg::NumW+1:0] two_n;
    logic [abg_pkg::NumW+1:0] sum;
    for (int l = 0; l < 4; l++) begin
      den_e = (abg_pkg::NumW + 2)'(den_q[l % 2]);
      two_n = {num_q[l][abg_pkg::NumW-1], num_q[l], 1'b0};
      sum   = num_q[l][abg_pkg::NumW-1] ? den_e - two_n : den_e + two_n;
      div_req_o[l].start    = div_start;
      div_req_o[l].dividend = sum[abg_pkg::DivdW-1:0];
      div_req_o[l].divisor  = {den_q[l % 2], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      s_q         <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cell_start) begin
        cnt_q <= eff_count;
        s_q   <= '0;
      end else if (out_load) begin
        s_q <= s_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [abg_pkg::NumW-1:0] a_s;
    logic signed [abg_pkg::NumW-1:0] b_s;
    logic signed [abg_pkg::NumW-1:0] lo;
    logic signed [abg_pkg::NumW-1:0] hi;
    if (tab_we) begin
      wtab_q[TabW'(entry_i.slot)] <= entry_i.pw;
      htab_q[TabW'(entry_i.slot)] <= entry_i.ph;
    end
    if (cell_start) begin
      cell_q <= entry_i;
    end
    if (state_q == abg_pkg::ST_MUL) begin
      for (int a = 0; a < 2; a++) begin
        pa_q[a]  <= abg_pkg::ProdAW'(pos[a]) * abg_pkg::ProdAW'(mult[a]);
        pb_q[a]  <= derived ? abg_pkg::ProdBW'(lay[a]) * abg_pkg::ProdBW'(bsz[a])
                            : abg_pkg::ProdBW'(bsz[a]);
        den_q[a] <= derived ? abg_pkg::DenW'(lay[a]) * abg_pkg::DenW'(img[a])
                            : abg_pkg::DenW'(img[a]);
      end
    end
    if (state_q == abg_pkg::ST_SUM) begin
      for (int a = 0; a < 2; a++) begin
        a_s = $signed(abg_pkg::NumW'(pa_q[a]));
        b_s = derived ? $signed(abg_pkg::NumW'(pb_q[a]) << 3)
                      : $signed(abg_pkg::NumW'(pb_q[a]) << 7);
        lo  = a_s - b_s;
        hi  = a_s + b_s;
        num_q[a]     <= derived ? (lo <<< 8) : (lo <<< 4);
        num_q[a + 2] <= derived ? (hi <<< 8) : (hi <<< 4);
      end
    end
    if (out_load) begin
      out_q.prior_index <= s_q[abg_pkg::SlotW-1:0];
      out_q.x_min <= clamp_coord(num_q[0][abg_pkg::NumW-1], div_rsp_i[0].quotient,
                                 cfg_i.clip_enable);
      out_q.y_min <= clamp_coord(num_q[1][abg_pkg::NumW-1], div_rsp_i[1].quotient,
                                 cfg_i.clip_enable);
      out_q.x_max <= clamp_coord(num_q[2][abg_pkg::NumW-1], div_rsp_i[2].quotient,
                                 cfg_i.clip_enable);
      out_q.y_max <= clamp_coord(num_q[3][abg_pkg::NumW-1], div_rsp_i[3].quotient,
                                 cfg_i.clip_enable);
      out_q.last_box <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/anchor_box_generator_unit.sv -----
// ----------------------------------------------------------------------------
// anchor_box_generator_unit: clustered prior box generator
// Stores prior sizes and emits one normalised box per prior for each grid
// cell, with corners in signed Q3.16, rounded, clamped or saturated.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Transaction
//   in        input      in_valid_i/in_stall_o   load prior or cell request
//   out       output     out_valid_o/out_stall_i one box per prior
//   cfg       input      cfg_valid_i/cfg_ready_o register index and write data
//
// A load writes the prior tables in the back end without leaving the idle state.
// A cell runs, for each of its N priors, a multiply step, a numerator step, a
// divider launch, the bit-serial division, a step to see the dividers finish
// and a load of the output register, which waits while the output is stalled;
// the bit-serial dividers take the longest.
// Reset is asynchronous and active low; it clears control state and returns
// the configuration registers to their reset values. The prior tables are
// not cleared. The front keeps taking transactions into a two-entry queue
// while the back end is busy or the output is stalled, until the queue is full.
//
module anchor_box_generator_unit #(
  parameter int unsigned MaxPriors = abg_pkg::MaxPriorsDef,
  parameter int unsigned MaxGrid   = abg_pkg::MaxGridDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  abg_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output abg_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [abg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [abg_pkg::CfgDataW-1:0]   cfg_data_i
);

  abg_pkg::cfg_t     cfg_q;
  logic              push, pop, q_empty, q_full;
  abg_pkg::work_t    push_entry, head_entry;
  abg_pkg::div_req_t div_req [4];
  abg_pkg::div_rsp_t div_rsp [4];
  logic [3:0]        div_busy;

  // Configuration is always taken; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_enable      <= 1'b0;
      cfg_q.center_offset    <= abg_pkg::OffW'(128);
      cfg_q.step_x           <= '0;
      cfg_q.step_y           <= '0;
      cfg_q.image_width_set  <= '0;
      cfg_q.image_height_set <= '0;
      cfg_q.prior_count      <= abg_pkg::CountW'(1);
    end else if (cfg_valid_i) begin
      unique case (abg_pkg::cfg_idx_e'(cfg_index_i))
        abg_pkg::CFG_CLIP:        cfg_q.clip_enable      <= cfg_data_i[0];
        abg_pkg::CFG_OFFSET:      cfg_q.center_offset    <= cfg_data_i[abg_pkg::OffW-1:0];
        abg_pkg::CFG_STEP_X:      cfg_q.step_x           <= cfg_data_i;
        abg_pkg::CFG_STEP_Y:      cfg_q.step_y           <= cfg_data_i;
        abg_pkg::CFG_IMG_W:       cfg_q.image_width_set  <= cfg_data_i[abg_pkg::ImgW-1:0];
        abg_pkg::CFG_IMG_H:       cfg_q.image_height_set <= cfg_data_i[abg_pkg::ImgW-1:0];
        abg_pkg::CFG_PRIOR_COUNT: cfg_q.prior_count      <= cfg_data_i[abg_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Front: classifies each input transaction and queues it.
  abg_front #(
    .MaxGrid(MaxGrid)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  abg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // Back: table writes and the per-prior box sequence.
  abg_back #(
    .MaxPriors(MaxPriors)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .entry_i    (head_entry),
    .pop_o      (pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Four dividers, one per box edge, run in lockstep.
  for (genvar g = 0; g < 4; g++) begin : gen_div
    abg_div u_div (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .req_i (div_req[g]),
      .rsp_o (div_rsp[g])
    );
    assign div_busy[g] = div_rsp[g].busy;
  end

`ifndef SYNTHESIS
  // The edge dividers are launched together and must finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_busy == 4'b0000) || (div_busy == 4'b1111))
    else $error("edge dividers out of step");

  // A divider is never restarted while it is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req[0].start |-> (div_busy == 4'b0000))
    else $error("divider launched while busy");

  // A new box only appears once all dividers have finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (div_busy == 4'b0000))
    else $error("box presented while division in progress");
`endif

endmodule
